[rtl/ktp_pkg.sv]
// Shared types, codes and reset values for the key to pointer mapper.
package ktp_pkg;

  localparam int SPEED_WIDTH_DEF = 16;
  localparam int CMD_DEPTH_DEF   = 2;
  localparam int OUT_DEPTH_DEF   = 2;

  localparam int KEY_W       = 10;
  localparam int CFG_INDEX_W = 3;

  localparam logic [4:0] EV_KEY = 5'd1;

  localparam logic [KEY_W-1:0] BUTTON_LEFT = 10'd272;
  localparam logic [KEY_W-1:0] AXIS_X      = 10'd0;
  localparam logic [KEY_W-1:0] AXIS_Y      = 10'd1;

  localparam logic [1:0] KIND_SYNC = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_REL  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE_KEY   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_KEY = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_UP_KEY     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DOWN_KEY   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_KEY   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_KEY  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_SPD   = 3'd6;

  // Default key map: caps lock, J, W, X, A, D
  localparam logic [KEY_W-1:0] MODE_KEY_RST   = 10'd58;
  localparam logic [KEY_W-1:0] BUTTON_KEY_RST = 10'd36;
  localparam logic [KEY_W-1:0] UP_KEY_RST     = 10'd17;
  localparam logic [KEY_W-1:0] DOWN_KEY_RST   = 10'd45;
  localparam logic [KEY_W-1:0] LEFT_KEY_RST   = 10'd30;
  localparam logic [KEY_W-1:0] RIGHT_KEY_RST  = 10'd32;
  localparam logic [KEY_W-1:0] INIT_SPEED_RST = 10'd10;

  // Held slot labels: empty, or direction index plus one
  localparam logic [2:0] SLOT_EMPTY = 3'd0;

  typedef struct packed {
    logic [4:0]       event_kind;
    logic [KEY_W-1:0] key_code;
    logic [1:0]       key_value;
  } event_t;

  typedef struct packed {
    logic [1:0]         out_kind;
    logic [KEY_W-1:0]   out_code;
    logic signed [15:0] out_value;
    logic               last_of_run;
  } result_t;

  typedef enum logic [1:0] {
    CMD_MODE_REL = 2'd0,
    CMD_POINTER  = 2'd1,
    CMD_PASS     = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic             dir_hit;
    logic [1:0]       dir_idx;
    logic             click_hit;
    logic             down;
    logic [KEY_W-1:0] code;
    logic [1:0]       value;
  } cmd_t;

endpackage

[rtl/ktp_fifo.sv]
// Small register queue used between the front, the back and the result port.
module ktp_fifo #(
  parameter type item_t = logic,
  parameter int  Depth  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  item_t          mem [Depth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

[rtl/ktp_front.sv]
// Front end: key map registers, mode tracking and event classification.
module ktp_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  ktp_pkg::event_t                     item,
  output logic                                full,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ktp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ktp_pkg::KEY_W-1:0]           cfg_data,
  output ktp_pkg::cmd_t                       cmd,
  output logic                                cmd_push,
  input  logic                                cmd_full,
  output logic [ktp_pkg::KEY_W-1:0]           init_speed
);
  import ktp_pkg::*;

  logic [KEY_W-1:0] mode_key;
  logic [KEY_W-1:0] button_key;
  logic [KEY_W-1:0] up_key;
  logic [KEY_W-1:0] down_key;
  logic [KEY_W-1:0] left_key;
  logic [KEY_W-1:0] right_key;
  logic             pointer_mode;

  logic accept;
  logic is_key;
  logic mode_hit;
  logic down;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;
  assign accept    = push && !cmd_full;
  assign is_key    = (item.event_kind == EV_KEY);
  assign mode_hit  = (item.key_code == mode_key);
  assign down      = (item.key_value != 2'd0);

  always_comb begin
    cmd.op        = mode_hit ? CMD_MODE_REL : (pointer_mode ? CMD_POINTER : CMD_PASS);
    cmd.dir_hit   = 1'b1;
    cmd.dir_idx   = 2'd0;
    cmd.click_hit = (item.key_code == button_key);
    cmd.down      = down;
    cmd.code      = item.key_code;
    cmd.value     = item.key_value;
    // First matching direction wins
    priority if (item.key_code == up_key) begin
      cmd.dir_idx = 2'd0;
    end else if (item.key_code == down_key) begin
      cmd.dir_idx = 2'd1;
    end else if (item.key_code == left_key) begin
      cmd.dir_idx = 2'd2;
    end else if (item.key_code == right_key) begin
      cmd.dir_idx = 2'd3;
    end else begin
      cmd.dir_hit = 1'b0;
    end
  end

  // Drop non-key events and mode key presses here
  assign cmd_push = accept && is_key && !(mode_hit && down);

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_mode <= 1'b0;
    end else if (accept && is_key && mode_hit) begin
      pointer_mode <= down;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_key   <= MODE_KEY_RST;
      button_key <= BUTTON_KEY_RST;
      up_key     <= UP_KEY_RST;
      down_key   <= DOWN_KEY_RST;
      left_key   <= LEFT_KEY_RST;
      right_key  <= RIGHT_KEY_RST;
      init_speed <= INIT_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE_KEY:   mode_key   <= cfg_data;
        REG_BUTTON_KEY: button_key <= cfg_data;
        REG_UP_KEY:     up_key     <= cfg_data;
        REG_DOWN_KEY:   down_key   <= cfg_data;
        REG_LEFT_KEY:   left_key   <= cfg_data;
        REG_RIGHT_KEY:  right_key  <= cfg_data;
        REG_BASE_SPD:   init_speed <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/ktp_back.sv]
// Back end: held slots, speeds, button state and result sequencing.
module ktp_back #(
  parameter int SPEED_WIDTH = ktp_pkg::SPEED_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ktp_pkg::cmd_t             cmd,
  input  logic                      cmd_empty,
  output logic                      cmd_pop,
  input  logic [ktp_pkg::KEY_W-1:0] init_speed,
  output ktp_pkg::result_t          res,
  output logic                      res_push,
  input  logic                      res_full
);
  import ktp_pkg::*;

  localparam int SW = SPEED_WIDTH;
  localparam int BW = (SW > 11) ? SW : 11;
  localparam int MW = (SW > 17) ? SW : 17;
  localparam longint LIM_L = (longint'(1) << (SW - 1)) - 1;
  localparam longint RST_L = (longint'(INIT_SPEED_RST) > LIM_L) ? LIM_L
                                                                : longint'(INIT_SPEED_RST);
  localparam logic signed [SW-1:0] LIM     = SW'(LIM_L);
  localparam logic signed [SW-1:0] RST_SPD = SW'(RST_L);
  localparam logic signed [MW-1:0] OUT_MAX = MW'(32767);

  // Result order within one item
  localparam int P_KEY    = 0;
  localparam int P_SYNC_A = 1;
  localparam int P_MOVE0  = 2;
  localparam int P_MOVE1  = 3;
  localparam int P_SYNC_B = 4;

  logic [4:0]             pending;
  logic                   button_down;
  logic [2:0]             slot0;
  logic [2:0]             slot1;
  logic signed [SW-1:0]   speed [4];
  logic [KEY_W-1:0]       cur_code;
  logic signed [15:0]     cur_value;

  logic [4:0]             sel;
  logic                   last;
  logic                   emit;
  logic                   is_move;
  logic [2:0]             move_lab;
  logic [1:0]             move_dir;
  logic signed [SW-1:0]   sp;
  logic signed [MW-1:0]   sp_w;
  logic signed [15:0]     sp_out;
  logic signed [SW-1:0]   sp_grow;

  logic [BW-1:0]          base_w;
  logic signed [SW-1:0]   base_sp;

  logic [4:0]             pend_next;
  logic [2:0]             slot0_next;
  logic [2:0]             slot1_next;
  logic                   button_next;
  logic                   reset_spd;
  logic [KEY_W-1:0]       code_next;
  logic signed [15:0]     value_next;
  logic [2:0]             lab;

  // Emit path: lowest pending result goes out first
  assign sel      = pending & (~pending + 5'd1);
  assign last     = ((pending & ~sel) == 5'd0);
  assign emit     = (pending != 5'd0) && !res_full;
  assign is_move  = sel[P_MOVE0] || sel[P_MOVE1];
  assign move_lab = sel[P_MOVE1] ? slot1 : slot0;
  assign move_dir = 2'(move_lab - 3'd1);
  assign sp       = speed[move_dir];
  assign sp_w     = MW'(sp);

  always_comb begin
    if (sp_w > OUT_MAX) begin
      sp_out = 16'sd32767;
    end else if (sp_w < -OUT_MAX) begin
      sp_out = -16'sd32767;
    end else begin
      sp_out = 16'(sp_w);
    end
    // Grow the magnitude, hold at the limit
    if (!sp[SW-1] && (sp != '0)) begin
      sp_grow = (sp < LIM) ? sp + SW'(1) : sp;
    end else begin
      sp_grow = (sp > -LIM) ? sp - SW'(1) : sp;
    end
  end

  always_comb begin
    res.last_of_run = last;
    priority if (sel[P_KEY]) begin
      res.out_kind  = KIND_KEY;
      res.out_code  = cur_code;
      res.out_value = cur_value;
    end else if (is_move) begin
      res.out_kind  = KIND_REL;
      res.out_code  = move_dir[1] ? AXIS_X : AXIS_Y;
      res.out_value = sp_out;
    end else begin
      res.out_kind  = KIND_SYNC;
      res.out_code  = '0;
      res.out_value = '0;
    end
  end

  assign res_push = emit;
  assign cmd_pop  = !cmd_empty && ((pending == 5'd0) || (emit && last));

  // Starting speed magnitude, clamped to the speed range
  always_comb begin
    base_w  = BW'(init_speed);
    base_sp = (base_w > BW'(LIM_L)) ? LIM : SW'(base_w);
  end

  // Apply one command to the state and plan its results
  always_comb begin
    pend_next   = '0;
    slot0_next  = slot0;
    slot1_next  = slot1;
    button_next = button_down;
    reset_spd   = 1'b0;
    code_next   = cmd.code;
    value_next  = signed'(16'(cmd.value));
    lab         = {1'b0, cmd.dir_idx} + 3'd1;
    unique case (cmd.op)
      CMD_MODE_REL: begin
        pend_next[P_KEY]    = button_down;
        pend_next[P_SYNC_A] = 1'b1;
        code_next           = BUTTON_LEFT;
        value_next          = '0;
        reset_spd           = 1'b1;
        slot0_next          = SLOT_EMPTY;
        slot1_next          = SLOT_EMPTY;
      end
      CMD_PASS: begin
        pend_next[P_KEY]    = 1'b1;
        pend_next[P_SYNC_A] = 1'b1;
      end
      CMD_POINTER: begin
        if (cmd.dir_hit) begin
          if (cmd.down) begin
            if (slot0 != lab) begin
              slot1_next = slot0;
              slot0_next = lab;
            end
          end else begin
            reset_spd  = 1'b1;
            slot0_next = SLOT_EMPTY;
            slot1_next = SLOT_EMPTY;
          end
        end
        if (cmd.click_hit) begin
          button_next         = cmd.down;
          pend_next[P_KEY]    = 1'b1;
          pend_next[P_SYNC_A] = 1'b1;
          code_next           = BUTTON_LEFT;
          value_next          = cmd.down ? 16'sd1 : 16'sd0;
        end
        if (slot0_next != SLOT_EMPTY) begin
          pend_next[P_MOVE0]  = 1'b1;
          pend_next[P_MOVE1]  = (slot1_next != SLOT_EMPTY);
          pend_next[P_SYNC_B] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= '0;
      button_down <= 1'b0;
      slot0       <= SLOT_EMPTY;
      slot1       <= SLOT_EMPTY;
      speed[0]    <= -RST_SPD;
      speed[1]    <= RST_SPD;
      speed[2]    <= -RST_SPD;
      speed[3]    <= RST_SPD;
    end else begin
      // A new command overrides the finishing one
      if (cmd_pop) begin
        pending     <= pend_next;
        button_down <= button_next;
        slot0       <= slot0_next;
        slot1       <= slot1_next;
      end else if (emit) begin
        pending <= pending & ~sel;
      end
      if (cmd_pop && reset_spd) begin
        speed[0] <= -base_sp;
        speed[1] <= base_sp;
        speed[2] <= -base_sp;
        speed[3] <= base_sp;
      end else if (emit && is_move) begin
        speed[move_dir] <= sp_grow;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_code  <= code_next;
      cur_value <= value_next;
    end
  end

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    speed[0] <= LIM && speed[0] >= -LIM && speed[1] <= LIM && speed[1] >= -LIM &&
    speed[2] <= LIM && speed[2] >= -LIM && speed[3] <= LIM && speed[3] >= -LIM)
    else $error("speed out of range");

  a_slots_distinct: assert property (@(posedge clk) disable iff (rst)
    (slot1 != SLOT_EMPTY) |-> (slot0 != SLOT_EMPTY && slot0 != slot1))
    else $error("held slots inconsistent");

  a_move_has_slot: assert property (@(posedge clk) disable iff (rst)
    (emit && is_move) |-> (move_lab != SLOT_EMPTY))
    else $error("move emitted for empty slot");

  a_move_not_last: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.out_kind == KIND_REL) |-> !res.last_of_run)
    else $error("move ended a run");

endmodule

[rtl/key_to_pointer_mapper.sv]
// An item's first result is poppable after the command queue, the pending register
// and the result queue. Throughput: one item per cycle for items with at most one
// result, else one result per cycle, while the result queue is not full; the back
// end's single result sequencer sets this. Non-key events and mode key presses give
// no result. Reset (rst, synchronous): empties both queues, restores the default key
// map and base speed, passthrough mode, button up, no held slots, speeds at -/+ base.
module key_to_pointer_mapper #(
  parameter int SPEED_WIDTH = ktp_pkg::SPEED_WIDTH_DEF,
  parameter int CMD_DEPTH   = ktp_pkg::CMD_DEPTH_DEF,
  parameter int OUT_DEPTH   = ktp_pkg::OUT_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  ktp_pkg::event_t                 item,
  output logic                            full,
  output logic                            empty,
  input  logic                            pop,
  output ktp_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ktp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ktp_pkg::KEY_W-1:0]       cfg_data
);
  import ktp_pkg::*;

  cmd_t             cmd_in;
  cmd_t             cmd_out;
  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_pop;
  logic             cmd_empty;
  logic [KEY_W-1:0] init_speed;
  result_t          res;
  logic             res_push;
  logic             res_full;

  ktp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd_in),
    .cmd_push   (cmd_push),
    .cmd_full   (cmd_full),
    .init_speed (init_speed)
  );

  ktp_fifo #(
    .item_t (cmd_t),
    .Depth  (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  ktp_back #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_out),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .init_speed (init_speed),
    .res        (res),
    .res_push   (res_push),
    .res_full   (res_full)
  );

  ktp_fifo #(
    .item_t (result_t),
    .Depth  (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule
